### hdl/ascending_value_sorter_unit_defines.svh
// ----------------------------------------------------------------------------
// Ascending value sorter - assertion macros
// Shared assertion forms for the checker of the sorter unit.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_VALUE_SORTER_UNIT_DEFINES_SVH
`define ASCENDING_VALUE_SORTER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define AVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// The expression must never be true.
`define AVS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

### hdl/avs_pkg.sv
// ----------------------------------------------------------------------------
// Ascending value sorter package
// Types and constants shared by the sorter cells, the top level and checker.
// ----------------------------------------------------------------------------
package avs_pkg;

   // Capacity of the cell chain and width of one value.
   localparam int MaxElements = 64;
   localparam int ValueBits   = 32;
   localparam int CountBits   = $clog2(MaxElements + 1);

   // Payload of one input transfer.
   typedef struct packed {
      logic signed [ValueBits-1:0] value;
      logic                        last_in;
   } req_data_type;

   // Payload of one result transfer.
   typedef struct packed {
      logic signed [ValueBits-1:0] sorted_value;
      logic                        last_out;
      logic                        overflow;
   } rsp_data_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

   // Collect a set, then hand it out in order.
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

### hdl/avs_cell.sv
// ----------------------------------------------------------------------------
// Ascending value sorter cell
// One slot of the sorted chain: takes part in insertion and shifts on drain.
// ----------------------------------------------------------------------------
module avs_cell (
   input  logic                                  clock,
   input  avs_pkg::cell_ctl_type                 ctl,
   input  logic signed [avs_pkg::ValueBits-1:0]  new_value,
   input  logic                                  occupied,
   input  logic                                  left_moves,
   input  logic signed [avs_pkg::ValueBits-1:0]  left_value,
   input  logic signed [avs_pkg::ValueBits-1:0]  right_value,
   output logic signed [avs_pkg::ValueBits-1:0]  value_o,
   output logic                                  moves_o
);

   logic signed [avs_pkg::ValueBits-1:0] value_ff;
   logic signed [avs_pkg::ValueBits-1:0] value_in;

   // The new value belongs in front of this slot when the slot is empty or
   // holds a strictly greater value; equal values keep their place.
   assign moves_o = !occupied || (new_value < value_ff);
   assign value_o = value_ff;

   // Drain shifts towards the head; insertion either takes the new value or
   // the neighbour's value, which moves up by one slot.
   always_comb begin
      priority if (ctl.drain) begin
         value_in = right_value;
      end else if (ctl.insert && moves_o) begin
         value_in = left_moves ? left_value : new_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### hdl/ascending_value_sorter_unit.sv
// ----------------------------------------------------------------------------
// Ascending value sorter unit
// Insertion sorter built from a chain of cells; sorts each set and emits it.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  req_     in         value, last_in (one element of a set)
//  rsp_     out        sorted_value, last_out, overflow (one sorted element)
//
//  The cells insert each element in order as it enters the chain, and the
//  next element can enter straight away. Results leave from the head of
//  the chain, which shifts towards its head as each one is taken.
//  Inputs are refused while a set is being emitted.
//  Reset empties the set count and the overflow flag; cell contents are
//  only ever read below the count.
//  A stalled result holds the chain unchanged until it is taken.
module ascending_value_sorter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  avs_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output avs_pkg::rsp_data_type rsp_data
);

   avs_pkg::state_type                state_ff;
   avs_pkg::state_type                state_in;
   logic [avs_pkg::CountBits-1:0]     count_ff;
   logic [avs_pkg::CountBits-1:0]     count_in;
   logic                              dropped_ff;
   logic                              dropped_in;
   logic                              not_full;
   avs_pkg::cell_ctl_type             ctl;

   logic signed [avs_pkg::ValueBits-1:0] cell_value [avs_pkg::MaxElements];
   logic                                 cell_moves [avs_pkg::MaxElements];
   logic                                 cell_occ   [avs_pkg::MaxElements];

   assign not_full = count_ff < avs_pkg::CountBits'(avs_pkg::MaxElements);

   // Sequencer: next state, count, overflow flag and cell control.
   // Ready is high throughout loading and valid throughout draining, so a
   // transfer in each state depends only on the other side's handshake.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      ctl        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         avs_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (not_full) begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_in) begin
                  state_in = avs_pkg::ST_DRAIN;
               end
            end
         end
         avs_pkg::ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.drain = 1'b1;
               count_in  = count_ff - 1'b1;
               if (rsp_data.last_out) begin
                  state_in   = avs_pkg::ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = avs_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= avs_pkg::ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // The head of the chain always holds the smallest remaining value.
   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.last_out     = (count_ff == avs_pkg::CountBits'(1));
   assign rsp_data.overflow     = dropped_ff;

   // Chain of cells; the head has no left neighbour and the tail no right.
   for (genvar i = 0; i < avs_pkg::MaxElements; i++) begin : g_cell
      localparam logic [avs_pkg::CountBits-1:0] Index = avs_pkg::CountBits'(i);
      logic                                 left_moves;
      logic signed [avs_pkg::ValueBits-1:0] left_value;
      logic signed [avs_pkg::ValueBits-1:0] right_value;

      assign cell_occ[i] = Index < count_ff;

      if (i == 0) begin : g_head
         assign left_moves = 1'b0;
         assign left_value = req_data.value;
      end else begin : g_body
         assign left_moves = cell_moves[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == avs_pkg::MaxElements - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      avs_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_value   (req_data.value),
         .occupied    (cell_occ[i]),
         .left_moves  (left_moves),
         .left_value  (left_value),
         .right_value (right_value),
         .value_o     (cell_value[i]),
         .moves_o     (cell_moves[i])
      );
   end

endmodule

### hdl/avs_checker.sv
// ----------------------------------------------------------------------------
// Ascending value sorter checker
// Port-level assertions on the sorter unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "ascending_value_sorter_unit_defines.svh"

module avs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input avs_pkg::req_data_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input avs_pkg::rsp_data_type rsp_data
);

   // Loading and emitting never overlap.
   `AVS_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)

   // A set's final element ends loading.
   `AVS_ASSERT_NEXT(a_last_stops_load, clock, reset,
      req_valid && req_ready && req_data.last_in, !req_ready)

   // Results follow one another until the final one is taken.
   `AVS_ASSERT_NEXT(a_drain_continues, clock, reset,
      rsp_valid && rsp_ready && !rsp_data.last_out, rsp_valid)

   // Taking the final result reopens the input.
   `AVS_ASSERT_NEXT(a_reopen, clock, reset,
      rsp_valid && rsp_ready && rsp_data.last_out, req_ready && !rsp_valid)

   // A stalled result holds.
   `AVS_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind ascending_value_sorter_unit avs_checker u_avs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
